// ===== hw/rtl/qsbs_pkg.sv =====
// Shared types and constants of the quicksort buffer sorter.
`timescale 1ns / 1ps

package qsbs_pkg;

   localparam int DATA_W      = 32;
   localparam int IDX_W       = 8;
   localparam int FIELD_W     = 7;
   localparam int STACK_SLOTS = 64;
   localparam int STACK_AW    = 6;
   localparam int STACK_CW    = 7;

   typedef logic signed [IDX_W-1:0] idx_type;
   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic [FIELD_W-1:0] lo;
      logic [FIELD_W-1:0] hi;
   } range_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      logic      clear;
      range_type data;
   } stk_ctrl_type;

endpackage

// ===== hw/rtl/qsbs_buffer.sv =====
// Sort buffer: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module qsbs_buffer #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [$clog2(DEPTH)-1:0]    waddr,
   input  qsbs_pkg::data_type          wdata,
   input  logic [$clog2(DEPTH)-1:0]    raddr,
   output qsbs_pkg::data_type          rdata
);

   qsbs_pkg::data_type mem [DEPTH];
   qsbs_pkg::data_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/qsbs_stack.sv =====
// Range stack: memory of packed index ranges with its top pointer.
`timescale 1ns / 1ps

module qsbs_stack (
   input  logic                    clock,
   input  logic                    reset,
   input  qsbs_pkg::stk_ctrl_type  ctrl,
   output qsbs_pkg::range_type     pop_data,
   output logic                    empty
);

   qsbs_pkg::range_type               mem [qsbs_pkg::STACK_SLOTS];
   qsbs_pkg::range_type               rdata_ff;
   logic [qsbs_pkg::STACK_CW-1:0]     top_ff;
   logic [qsbs_pkg::STACK_CW-1:0]     top_in;
   logic [qsbs_pkg::STACK_CW-1:0]     top_dec;
   logic                              push_ok;

   assign top_dec = top_ff - qsbs_pkg::STACK_CW'(1);
   assign push_ok = ctrl.push && (top_ff < qsbs_pkg::STACK_CW'(qsbs_pkg::STACK_SLOTS));

   always_comb begin
      top_in = top_ff;
      if (ctrl.clear) begin
         top_in = '0;
      end else if (push_ok) begin
         top_in = top_ff + qsbs_pkg::STACK_CW'(1);
      end else if (ctrl.pop && !empty) begin
         top_in = top_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else begin
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok && !ctrl.clear) begin
         mem[top_ff[qsbs_pkg::STACK_AW-1:0]] <= ctrl.data;
      end
      rdata_ff <= mem[top_dec[qsbs_pkg::STACK_AW-1:0]];
   end

   assign empty    = (top_ff == '0);
   assign pop_data = rdata_ff;

endmodule

// ===== hw/rtl/quicksort_buffer_sorter_unit.sv =====
// Top level: input buffering, quicksort sequencer and sorted output stream.
//
//   channel  dir  tdata               tlast        tuser
//   req_     in   value[31:0]         last         -
//   rsp_     out  sorted_value[31:0]  end_of_set   overflowed
//
// Words are loaded while req_tready is high. The sort then runs on one buffer read port:
// scan steps, exchanges, partitioned ranges and popped empty ranges all share that
// port. Each output word is read from the buffer and held until taken before the next read.
// req_tready is high only while loading. Reset is synchronous and clears control.
// A stalled rsp_ word holds until taken.
`timescale 1ns / 1ps

module quicksort_buffer_sorter_unit #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sorted_value[31:0]
   output logic        rsp_tlast,
   output logic        rsp_tuser    // overflowed
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_START    = 4'd1;
   localparam logic [3:0] S_POP      = 4'd2;
   localparam logic [3:0] S_RANGE    = 4'd3;
   localparam logic [3:0] S_PIVOT    = 4'd4;
   localparam logic [3:0] S_CHECK    = 4'd5;
   localparam logic [3:0] S_SCANL    = 4'd6;
   localparam logic [3:0] S_SCANH    = 4'd7;
   localparam logic [3:0] S_SWAP     = 4'd8;
   localparam logic [3:0] S_PUSH1    = 4'd9;
   localparam logic [3:0] S_PUSH2    = 4'd10;
   localparam logic [3:0] S_OUT_LD   = 4'd11;
   localparam logic [3:0] S_OUT_HOLD = 4'd12;

   logic [3:0]            state_ff, state_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic                  dropped_ff, dropped_in;
   qsbs_pkg::idx_type     lo_ff, lo_in, hi_ff, hi_in;
   qsbs_pkg::idx_type     scan_low_ff, scan_low_in, scan_high_ff, scan_high_in;
   qsbs_pkg::data_type    pivot_ff, pivot_in;
   qsbs_pkg::data_type    a_ff, a_in;
   logic [AW-1:0]         k_ff, k_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   qsbs_pkg::data_type    rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic                  buf_we;
   logic [AW-1:0]         buf_waddr;
   qsbs_pkg::data_type    buf_wdata;
   logic [AW-1:0]         buf_raddr;
   qsbs_pkg::data_type    buf_rdata;

   qsbs_pkg::stk_ctrl_type stk_ctrl;
   qsbs_pkg::range_type    stk_rdata;
   logic                   stk_empty;

   qsbs_pkg::idx_type     pop_lo, pop_hi, count_idx;
   logic [qsbs_pkg::IDX_W-1:0] mid_sum;
   logic                  req_fire, rsp_fire, is_last_word;
   logic                  less_pivot, greater_pivot;

   qsbs_buffer #(
      .DEPTH(DEPTH)
   ) u_buffer (
      .clock (clock),
      .we    (buf_we),
      .waddr (buf_waddr),
      .wdata (buf_wdata),
      .raddr (buf_raddr),
      .rdata (buf_rdata)
   );

   qsbs_stack u_stack (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (stk_ctrl),
      .pop_data (stk_rdata),
      .empty    (stk_empty)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;

   assign pop_lo    = $signed({1'b0, stk_rdata.lo});
   assign pop_hi    = $signed({1'b0, stk_rdata.hi});
   assign count_idx = $signed({{(qsbs_pkg::IDX_W - CW){1'b0}}, fill_ff});
   assign mid_sum   = {1'b0, stk_rdata.lo} + {1'b0, stk_rdata.hi};

   assign less_pivot    = buf_rdata < pivot_ff;
   assign greater_pivot = buf_rdata > pivot_ff;
   assign is_last_word  = (CW'(k_ff) == fill_ff - CW'(1));

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      scan_low_in  = scan_low_ff;
      scan_high_in = scan_high_ff;
      pivot_in     = pivot_ff;
      a_in         = a_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      buf_we       = 1'b0;
      buf_waddr    = fill_ff[AW-1:0];
      buf_wdata    = $signed(req_tdata);
      buf_raddr    = k_ff;
      stk_ctrl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (fill_ff < CW'(DEPTH)) begin
                  buf_we  = 1'b1;
                  fill_in = fill_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            if (fill_ff > CW'(1)) begin
               stk_ctrl.push    = 1'b1;
               stk_ctrl.data.lo = '0;
               stk_ctrl.data.hi = qsbs_pkg::FIELD_W'(fill_ff - CW'(1));
            end
            state_in = S_POP;
         end
         S_POP: begin
            if (stk_empty) begin
               k_in      = '0;
               buf_raddr = '0;
               state_in  = S_OUT_LD;
            end else begin
               stk_ctrl.pop = 1'b1;
               state_in     = S_RANGE;
            end
         end
         S_RANGE: begin
            buf_raddr = mid_sum[AW:1];
            if (pop_lo >= count_idx || pop_hi >= count_idx || pop_lo >= pop_hi) begin
               state_in = S_POP;
            end else begin
               lo_in        = pop_lo;
               hi_in        = pop_hi;
               scan_low_in  = pop_lo;
               scan_high_in = pop_hi;
               state_in     = S_PIVOT;
            end
         end
         S_PIVOT: begin
            pivot_in = buf_rdata;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            buf_raddr = scan_low_ff[AW-1:0];
            if (scan_low_ff <= scan_high_ff) begin
               state_in = S_SCANL;
            end else begin
               state_in = S_PUSH1;
            end
         end
         S_SCANL: begin
            if (scan_low_ff < hi_ff && less_pivot) begin
               scan_low_in = scan_low_ff + qsbs_pkg::idx_type'(1);
               buf_raddr   = scan_low_in[AW-1:0];
            end else begin
               a_in      = buf_rdata;
               buf_raddr = scan_high_ff[AW-1:0];
               state_in  = S_SCANH;
            end
         end
         S_SCANH: begin
            buf_raddr = scan_high_ff[AW-1:0];
            if (scan_high_ff > lo_ff && greater_pivot) begin
               scan_high_in = scan_high_ff - qsbs_pkg::idx_type'(1);
               buf_raddr    = scan_high_in[AW-1:0];
            end else if (scan_low_ff <= scan_high_ff) begin
               buf_we    = 1'b1;
               buf_waddr = scan_low_ff[AW-1:0];
               buf_wdata = buf_rdata;
               state_in  = S_SWAP;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_SWAP: begin
            buf_we       = 1'b1;
            buf_waddr    = scan_high_ff[AW-1:0];
            buf_wdata    = a_ff;
            scan_low_in  = scan_low_ff + qsbs_pkg::idx_type'(1);
            scan_high_in = scan_high_ff - qsbs_pkg::idx_type'(1);
            state_in     = S_CHECK;
         end
         S_PUSH1: begin
            if (scan_low_ff < hi_ff) begin
               stk_ctrl.push    = 1'b1;
               stk_ctrl.data.lo = scan_low_ff[qsbs_pkg::FIELD_W-1:0];
               stk_ctrl.data.hi = hi_ff[qsbs_pkg::FIELD_W-1:0];
            end
            state_in = S_PUSH2;
         end
         S_PUSH2: begin
            if (lo_ff < scan_high_ff) begin
               stk_ctrl.push    = 1'b1;
               stk_ctrl.data.lo = lo_ff[qsbs_pkg::FIELD_W-1:0];
               stk_ctrl.data.hi = scan_high_ff[qsbs_pkg::FIELD_W-1:0];
            end
            state_in = S_POP;
         end
         S_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = buf_rdata;
            rsp_last_in  = is_last_word;
            rsp_user_in  = dropped_ff;
            state_in     = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  fill_in        = '0;
                  dropped_in     = 1'b0;
                  stk_ctrl.clear = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  k_in      = k_ff + AW'(1);
                  buf_raddr = k_in;
                  state_in  = S_OUT_LD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      scan_low_ff  <= scan_low_in;
      scan_high_ff <= scan_high_in;
      pivot_ff     <= pivot_in;
      a_ff         <= a_in;
      k_ff         <= k_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== tb/sv/quicksort_buffer_sorter_unit_tb.sv =====
// Testbench for the quicksort buffer sorter: random and directed sets checked against a predictor.
`timescale 1ns / 1ps

module quicksort_buffer_sorter_unit_tb;

   localparam int DEPTH        = 64;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int DRAIN_LIMIT  = 400000;

   typedef enum int {
      VAL_FULL,
      VAL_NARROW,
      VAL_EXTREME
   } value_mode_type;

   typedef struct packed {
      qsbs_pkg::data_type value;
      logic               end_of_set;
      logic               overflowed;
   } sorted_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // value[31:0]
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // sorted_value[31:0]
   logic        rsp_tlast;
   logic        rsp_tuser;         // overflowed

   sorted_word_type    sorted_expect_q[$];
   qsbs_pkg::data_type set_store[DEPTH];
   int                 set_fill    = 0;
   logic               set_dropped = 1'b0;
   int                 error_count = 0;
   int                 send_idle   = 0;
   int                 recv_idle   = 0;
   int                 words_sent  = 0;
   logic               hold_toggle = 1'b0;
   logic               hold_seen   = 1'b0;
   int                 hold_left   = 0;

   quicksort_buffer_sorter_unit #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Middle-pivot Hoare quicksort over the buffered set, explicit range stack.
   function automatic void quicksort_set(int count);
      int                 range_lo[$];
      int                 range_hi[$];
      int                 lo;
      int                 hi;
      int                 i;
      int                 j;
      qsbs_pkg::data_type pivot;
      qsbs_pkg::data_type tmp;
      if (count > 1) begin
         range_lo.push_back(0);
         range_hi.push_back(count - 1);
      end
      while (range_lo.size() > 0) begin
         lo = range_lo.pop_back();
         hi = range_hi.pop_back();
         if (lo >= hi) continue;
         i = lo;
         j = hi;
         pivot = set_store[(lo + hi) / 2];
         while (i <= j) begin
            while (i < hi && set_store[i] < pivot) i++;
            while (j > lo && set_store[j] > pivot) j--;
            if (i <= j) begin
               tmp = set_store[i];
               set_store[i] = set_store[j];
               set_store[j] = tmp;
               i++;
               j--;
            end
         end
         if (i < hi) begin
            range_lo.push_back(i);
            range_hi.push_back(hi);
         end
         if (lo < j) begin
            range_lo.push_back(lo);
            range_hi.push_back(j);
         end
      end
   endfunction

   function automatic void absorb_word(qsbs_pkg::data_type value, logic last);
      sorted_word_type w;
      if (set_fill < DEPTH) begin
         set_store[set_fill] = value;
         set_fill++;
      end else begin
         set_dropped = 1'b1;
      end
      if (last) begin
         quicksort_set(set_fill);
         for (int k = 0; k < set_fill; k++) begin
            w.value      = set_store[k];
            w.end_of_set = (k == set_fill - 1);
            w.overflowed = set_dropped;
            sorted_expect_q.push_back(w);
         end
         set_fill    = 0;
         set_dropped = 1'b0;
      end
   endfunction

   function automatic qsbs_pkg::data_type pick_value(value_mode_type mode);
      qsbs_pkg::data_type v;
      case (mode)
         VAL_NARROW: begin
            v = $signed($urandom_range(8)) - 4;
         end
         VAL_EXTREME: begin
            case ($urandom_range(3))
               0: v = 32'sh8000_0000;
               1: v = 32'sh7FFF_FFFF;
               2: v = 32'sh0000_0000;
               default: v = 32'shFFFF_FFFF;
            endcase
         end
         default: begin
            v = $urandom;
         end
      endcase
      return v;
   endfunction

   // valid stays high across back-to-back words; only idling and wait_drained lower it
   task automatic send_word(qsbs_pkg::data_type value, logic last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      absorb_word(value, last);
      words_sent++;
   endtask

   task automatic send_set(int size, value_mode_type mode);
      for (int k = 0; k < size; k++) begin
         send_word(pick_value(mode), k == size - 1);
      end
   endtask

   task automatic send_list(qsbs_pkg::data_type vals[$]);
      for (int k = 0; k < vals.size(); k++) begin
         send_word(vals[k], k == vals.size() - 1);
      end
   endtask

   task automatic wait_drained();
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (sorted_expect_q.size() > 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      send_list('{32'sh8000_0000});
      send_list('{32'sh7FFF_FFFF});
      send_list('{32'sd5, -32'sd3});
      send_list('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1,
                  32'sh8000_0000, 32'sh7FFF_FFFF});
      send_list('{32'sd7, 32'sd7, 32'sd7, 32'sd7});
      send_list('{32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5});
      wait_drained();
   endtask

   // full buffer, and last dropped on a full buffer
   task automatic test_overflow();
      for (int k = 0; k < DEPTH; k++) begin
         send_word(DEPTH - k, k == DEPTH - 1);
      end
      send_set(DEPTH + 1, VAL_FULL);
      wait_drained();
   endtask

   task automatic test_random(int s_idle, int r_idle, int quota);
      int             start;
      int             size;
      int             roll;
      value_mode_type mode;
      send_idle = s_idle;
      recv_idle = r_idle;
      start = words_sent;
      while (words_sent - start < quota) begin
         roll = $urandom_range(99);
         if (roll < 70) size = $urandom_range(12, 1);
         else if (roll < 90) size = $urandom_range(40, 13);
         else size = $urandom_range(DEPTH + 8, DEPTH - 4);
         roll = $urandom_range(99);
         if (roll < 55) mode = VAL_FULL;
         else if (roll < 85) mode = VAL_NARROW;
         else mode = VAL_EXTREME;
         send_set(size, mode);
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle = 0;
      recv_idle = 0;
      @(posedge clock);
      hold_toggle <= ~hold_toggle;
      send_set(40, VAL_FULL);
      send_set(20, VAL_FULL);
      send_set(8, VAL_NARROW);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      sorted_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sorted_expect_q.size() == 0) begin
            $display("%0t: unexpected word value=%0d end=%b ovf=%b",
                     $time, $signed(rsp_tdata), rsp_tlast, rsp_tuser);
            error_count++;
         end else begin
            w = sorted_expect_q.pop_front();
            if (rsp_tdata !== w.value) begin
               $display("%0t: sorted_value expected %0d actual %0d",
                        $time, w.value, $signed(rsp_tdata));
               error_count++;
            end
            if (rsp_tlast !== w.end_of_set) begin
               $display("%0t: end_of_set expected %b actual %b",
                        $time, w.end_of_set, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser !== w.overflowed) begin
               $display("%0t: overflowed expected %b actual %b",
                        $time, w.overflowed, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle = 12;
      recv_idle = 54;
      test_directed();
      test_overflow();
      test_random(12, 54, 40);
      test_random(54, 12, 40);
      test_random(0, 0, 40);
      test_backpressure();
      if (sorted_expect_q.size() > 0) begin
         $display("%0t: %0d words never arrived", $time, sorted_expect_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
